/* rtl/core/rgwh_pkg.sv */
package rgwh_pkg;

  localparam int NUM_BINS    = 64;
  localparam int FRAC_BITS   = 24;
  localparam int SCALE_FRAC  = 16;
  localparam int WEIGHT_FRAC = 56;
  localparam int PI6_FRAC    = 32;
  localparam logic [31:0] PI6_Q32 = 32'd2248839617;

  localparam int BIN_W     = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int IDX_W     = 6;
  localparam int BIN_SHIFT = FRAC_BITS + SCALE_FRAC;
  localparam int VOL_SHIFT = 3 * FRAC_BITS + PI6_FRAC - WEIGHT_FRAC;

  localparam logic [2:0] MODE_DIAM    = 3'd0;
  localparam logic [2:0] MODE_AXIAL   = 3'd1;
  localparam logic [2:0] MODE_SPEED   = 3'd2;
  localparam logic [2:0] MODE_RADIAL  = 3'd3;
  localparam logic [2:0] MODE_TANGENT = 3'd4;

  typedef enum logic [3:0] {
    REG_MODE     = 4'd0,
    REG_BOX_X    = 4'd1,
    REG_BOX_Y    = 4'd2,
    REG_BOX_Z    = 4'd3,
    REG_ORIGIN   = 4'd4,
    REG_SCALE    = 4'd5,
    REG_CENTRE_Y = 4'd6,
    REG_CENTRE_Z = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic        [30:0] diameter;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic               batch_last;
  } drop_in_t;

  typedef struct packed {
    logic             accepted;
    logic [IDX_W-1:0] bin_index;
    logic [31:0]      bin_count;
    logic [63:0]      bin_weight;
    logic             batch_done;
  } drop_out_t;

  typedef enum logic [4:0] {
    MS_NONE, MS_VYVY, MS_VZVZ, MS_DYDY, MS_DZDZ, MS_VYDY, MS_VZDZ, MS_VZDY, MS_VYDZ,
    MS_DIFF_LO, MS_DIFF_HI, MS_DD, MS_SQ_LO, MS_SQ_HI, MS_T0, MS_T1, MS_T2
  } mul_sel_t;

  typedef enum logic [3:0] {
    AC_NONE, AC_DD, AC_T_SET, AC_T_ADD, AC_Q_SET, AC_Q_ADD1, AC_Q_ADD2,
    AC_SQ_SET, AC_SQ_ADD, AC_NUM_SET, AC_NUM_ADD, AC_NUM_SUB,
    AC_DIFF, AC_BIN_SET, AC_BIN_ADD, AC_DECIDE
  } acc_op_t;

  typedef enum logic [2:0] {
    V_NONE, V_DIAM, V_VX, V_ROOT, V_ZERO, V_DIV
  } v_op_t;

  typedef struct packed {
    logic     load;
    mul_sel_t mul;
    acc_op_t  acc;
    v_op_t    vop;
    logic     root_start;
    logic     div_start;
    logic     update;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       root_done;
    logic       root_zero;
    logic       div_done;
    logic       out_busy;
  } dp_status_t;

endpackage

/* rtl/core/rgwh_isqrt.sv */
module rgwh_isqrt import rgwh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] x,
  output logic        done,
  output logic [31:0] root
);

  localparam int ROOT_STEPS = 32;

  logic        busy;
  logic [4:0]  cnt;
  logic [32:0] rem;
  logic [63:0] xs;
  logic [34:0] r_sh;
  logic [34:0] trial;
  logic        ge;

  // one root bit per cycle, two radicand bits shifted in
  always_comb begin
    r_sh  = {rem, xs[63:62]};
    trial = {1'b0, root, 2'b01};
    ge    = r_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        root <= '0;
        xs   <= x;
      end else if (busy) begin
        rem  <= ge ? 33'(r_sh - trial) : r_sh[32:0];
        root <= {root[30:0], ge};
        xs   <= {xs[61:0], 2'b00};
        cnt  <= cnt + 5'd1;
        if (cnt == 5'(ROOT_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/core/rgwh_div.sv */
module rgwh_div import rgwh_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic        [31:0] den,
  output logic               done,
  output logic signed [63:0] quo
);

  localparam int DIV_STEPS = 64;

  logic        busy;
  logic [5:0]  cnt;
  logic [31:0] rem;
  logic [31:0] den_r;
  logic [63:0] qs;
  logic        neg;
  logic [32:0] r_sh;
  logic        ge;

  // restoring divide on magnitudes, sign fixed at the end
  always_comb begin
    r_sh = {rem, qs[63]};
    ge   = r_sh >= {1'b0, den_r};
    quo  = neg ? -$signed(qs) : $signed(qs);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        rem   <= '0;
        den_r <= den;
        neg   <= num[63];
        qs    <= num[63] ? 64'(-num) : 64'(num);
      end else if (busy) begin
        rem <= ge ? 32'(r_sh - {1'b0, den_r}) : r_sh[31:0];
        qs  <= {qs[62:0], ge};
        cnt <= cnt + 6'd1;
        if (cnt == 6'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/core/rgwh_dp.sv */
module rgwh_dp import rgwh_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  drop_in_t   in_data,
  input  logic       cfg_valid,
  input  logic [3:0] cfg_index,
  input  logic [63:0] cfg_data,
  input  dp_cmd_t    cmd,
  output dp_status_t st,
  output drop_out_t  out_data,
  output logic       out_valid,
  input  logic       out_ready
);

  localparam logic signed [32:0] SAT_MAX = 33'sd2147483647;
  localparam logic signed [32:0] SAT_MIN = -33'sd2147483647;

  logic [2:0]         mode;
  logic [63:0]        box_x, box_y, box_z;
  logic signed [31:0] origin, centre_y, centre_z;
  logic [31:0]        scale;

  drop_in_t           item;
  logic               inbox;
  logic signed [31:0] dy, dz;
  logic signed [32:0] dy_w, dz_w;
  logic signed [31:0] dy_s, dz_s;

  logic signed [32:0] ma, mb;
  logic signed [65:0] prod_w, mreg;
  logic [61:0]        dd;
  logic [92:0]        t;
  logic [127:0]       q;
  logic [63:0]        sq;
  logic signed [63:0] num, v;
  logic signed [64:0] diff;
  logic [95:0]        prod;

  logic               ok;
  logic [BIN_W-1:0]   bin, bin_sel;
  logic               in_bin;
  logic [63:0]        vol;

  logic [63:0]         wmem [NUM_BINS];
  logic [31:0]         cmem [NUM_BINS];
  logic [NUM_BINS-1:0] valid;
  logic [63:0]         rd_w;
  logic [31:0]         rd_c;
  logic                rd_v;
  logic [63:0]         old_w, nw;
  logic [64:0]         sum_w;
  logic [31:0]         nc;

  logic [31:0]        root;
  logic               root_done;
  logic signed [63:0] quo;
  logic               div_done;

  function automatic logic in_bounds(logic signed [31:0] p, logic [63:0] b);
    return (p >= $signed(b[31:0])) && (p <= $signed(b[63:32]));
  endfunction

  rgwh_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.root_start),
    .x     (sq),
    .done  (root_done),
    .root  (root)
  );

  rgwh_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (num),
    .den   (root),
    .done  (div_done),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_DIAM;
      box_x    <= 64'h7FFF_FFFF_8000_0000;
      box_y    <= 64'h7FFF_FFFF_8000_0000;
      box_z    <= 64'h7FFF_FFFF_8000_0000;
      origin   <= '0;
      scale    <= 32'd65536;
      centre_y <= 32'sd2008233;
      centre_z <= 32'sd1739797;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MODE:     mode     <= cfg_data[2:0];
        REG_BOX_X:    box_x    <= cfg_data;
        REG_BOX_Y:    box_y    <= cfg_data;
        REG_BOX_Z:    box_z    <= cfg_data;
        REG_ORIGIN:   origin   <= cfg_data[31:0];
        REG_SCALE:    scale    <= cfg_data[31:0];
        REG_CENTRE_Y: centre_y <= cfg_data[31:0];
        REG_CENTRE_Z: centre_z <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // offsets from the axis, clamped symmetric
  always_comb begin
    dy_w = {in_data.pos_y[31], in_data.pos_y} - {centre_y[31], centre_y};
    dz_w = {in_data.pos_z[31], in_data.pos_z} - {centre_z[31], centre_z};
    dy_s = (dy_w > SAT_MAX) ? 32'sh7FFF_FFFF : (dy_w < SAT_MIN) ? -32'sh7FFF_FFFF
         : dy_w[31:0];
    dz_s = (dz_w > SAT_MAX) ? 32'sh7FFF_FFFF : (dz_w < SAT_MIN) ? -32'sh7FFF_FFFF
         : dz_w[31:0];
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.mul)
      MS_VYVY:    begin ma = {item.vel_y[31], item.vel_y}; mb = ma; end
      MS_VZVZ:    begin ma = {item.vel_z[31], item.vel_z}; mb = ma; end
      MS_DYDY:    begin ma = {dy[31], dy}; mb = ma; end
      MS_DZDZ:    begin ma = {dz[31], dz}; mb = ma; end
      MS_VYDY:    begin ma = {item.vel_y[31], item.vel_y}; mb = {dy[31], dy}; end
      MS_VZDZ:    begin ma = {item.vel_z[31], item.vel_z}; mb = {dz[31], dz}; end
      MS_VZDY:    begin ma = {item.vel_z[31], item.vel_z}; mb = {dy[31], dy}; end
      MS_VYDZ:    begin ma = {item.vel_y[31], item.vel_y}; mb = {dz[31], dz}; end
      MS_DIFF_LO: begin ma = {1'b0, diff[31:0]}; mb = {1'b0, scale}; end
      MS_DIFF_HI: begin ma = {1'b0, diff[63:32]}; mb = {1'b0, scale}; end
      MS_DD:      begin ma = {2'b0, item.diameter}; mb = ma; end
      MS_SQ_LO:   begin ma = {1'b0, dd[31:0]}; mb = {2'b0, item.diameter}; end
      MS_SQ_HI:   begin ma = {3'b0, dd[61:32]}; mb = {2'b0, item.diameter}; end
      MS_T0:      begin ma = {1'b0, t[31:0]}; mb = {1'b0, PI6_Q32}; end
      MS_T1:      begin ma = {1'b0, t[63:32]}; mb = {1'b0, PI6_Q32}; end
      MS_T2:      begin ma = {4'b0, t[92:64]}; mb = {1'b0, PI6_Q32}; end
      default: ;
    endcase
    prod_w = ma * mb;
  end

  always_comb begin
    vol     = ((q >> VOL_SHIFT) > 128'(64'hFFFF_FFFF_FFFF_FFFF)) ? '1 : 64'(q >> VOL_SHIFT);
    bin_sel = prod[BIN_SHIFT +: BIN_W];
    in_bin  = (prod >> BIN_SHIFT) < 96'(NUM_BINS);
    old_w   = rd_v ? rd_w : '0;
    sum_w   = {1'b0, old_w} + {1'b0, vol};
    nw      = sum_w[64] ? '1 : sum_w[63:0];
    nc      = !rd_v ? 32'd1 : (&rd_c) ? rd_c : rd_c + 32'd1;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item  <= in_data;
      dy    <= dy_s;
      dz    <= dz_s;
      inbox <= in_bounds(in_data.pos_x, box_x) && in_bounds(in_data.pos_y, box_y)
            && in_bounds(in_data.pos_z, box_z);
    end
    if (cmd.mul != MS_NONE) mreg <= prod_w;
    case (cmd.acc)
      AC_DD:      dd   <= mreg[61:0];
      AC_T_SET:   t    <= 93'(mreg[62:0]);
      AC_T_ADD:   t    <= t + {mreg[60:0], 32'b0};
      AC_Q_SET:   q    <= 128'(mreg[63:0]);
      AC_Q_ADD1:  q    <= q + {32'b0, mreg[63:0], 32'b0};
      AC_Q_ADD2:  q    <= q + {mreg[63:0], 64'b0};
      AC_SQ_SET:  sq   <= mreg[63:0];
      AC_SQ_ADD:  sq   <= sq + mreg[63:0];
      AC_NUM_SET: num  <= mreg[63:0];
      AC_NUM_ADD: num  <= num + mreg[63:0];
      AC_NUM_SUB: num  <= num - mreg[63:0];
      AC_DIFF:    diff <= {v[63], v} - {{33{origin[31]}}, origin};
      AC_BIN_SET: prod <= 96'(mreg[63:0]);
      AC_BIN_ADD: prod <= prod + {mreg[63:0], 32'b0};
      AC_DECIDE: begin
        // negative offsets land in bin zero only when the scale is zero
        ok   <= inbox && (mode <= MODE_TANGENT) && (diff[64] ? (scale == '0) : in_bin);
        bin  <= bin_sel;
        rd_w <= wmem[bin_sel];
        rd_c <= cmem[bin_sel];
        rd_v <= valid[bin_sel];
      end
      default: ;
    endcase
    case (cmd.vop)
      V_DIAM: v <= 64'(item.diameter);
      V_VX:   v <= 64'(item.vel_x);
      V_ROOT: v <= 64'(root);
      V_ZERO: v <= '0;
      V_DIV:  v <= quo;
      default: ;
    endcase
    if (cmd.update && ok) begin
      wmem[bin] <= nw;
      cmem[bin] <= nc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.update) begin
        out_valid <= 1'b1;
        if (ok) valid[bin] <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_data.accepted   <= ok;
      out_data.bin_index  <= ok ? IDX_W'(bin) : '0;
      out_data.bin_count  <= ok ? nc : '0;
      out_data.bin_weight <= ok ? nw : '0;
      out_data.batch_done <= item.batch_last;
    end
  end

  always_comb begin
    st.mode      = mode;
    st.root_done = root_done;
    st.root_zero = (root == '0);
    st.div_done  = div_done;
    st.out_busy  = out_valid && !out_ready;
  end

endmodule

/* rtl/core/rgwh_ctrl.sv */
module rgwh_ctrl import rgwh_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_DD_MUL, S_DD_ACC, S_T_LO, S_T_HI, S_T_ACC, S_Q0, S_Q1, S_Q2, S_Q_ACC,
    S_SQ_A, S_SQ_B, S_SQ_ACC, S_NUM_B, S_NUM_ACC, S_ROOT_START, S_ROOT_WAIT,
    S_DIV_START, S_DIV_WAIT, S_DIFF, S_BIN_LO, S_BIN_HI, S_BIN_ACC, S_DECIDE, S_UPDATE
  } state_t;

  state_t state, state_next;
  logic   speed, radial;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    speed          = (st.mode == MODE_SPEED);
    radial         = (st.mode == MODE_RADIAL);
    state_next     = state;
    in_ready       = (state == S_IDLE);
    cmd.load       = 1'b0;
    cmd.mul        = MS_NONE;
    cmd.acc        = AC_NONE;
    cmd.vop        = V_NONE;
    cmd.root_start = 1'b0;
    cmd.div_start  = 1'b0;
    cmd.update     = 1'b0;
    unique case (state)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_next = S_DD_MUL;
      end
      // volume: d*d, times d, times pi/6, in 32-bit chunks
      S_DD_MUL: begin cmd.mul = MS_DD; state_next = S_DD_ACC; end
      S_DD_ACC: begin cmd.acc = AC_DD; state_next = S_T_LO; end
      S_T_LO:   begin cmd.mul = MS_SQ_LO; state_next = S_T_HI; end
      S_T_HI:   begin cmd.mul = MS_SQ_HI; cmd.acc = AC_T_SET; state_next = S_T_ACC; end
      S_T_ACC:  begin cmd.acc = AC_T_ADD; state_next = S_Q0; end
      S_Q0:     begin cmd.mul = MS_T0; state_next = S_Q1; end
      S_Q1:     begin cmd.mul = MS_T1; cmd.acc = AC_Q_SET; state_next = S_Q2; end
      S_Q2:     begin cmd.mul = MS_T2; cmd.acc = AC_Q_ADD1; state_next = S_Q_ACC; end
      S_Q_ACC: begin
        cmd.acc = AC_Q_ADD2;
        unique case (st.mode) inside
          MODE_DIAM:  begin cmd.vop = V_DIAM; state_next = S_DIFF; end
          MODE_AXIAL: begin cmd.vop = V_VX; state_next = S_DIFF; end
          MODE_SPEED, MODE_RADIAL, MODE_TANGENT: state_next = S_SQ_A;
          default:    begin cmd.vop = V_ZERO; state_next = S_DIFF; end
        endcase
      end
      S_SQ_A: begin
        cmd.mul    = speed ? MS_VYVY : MS_DYDY;
        state_next = S_SQ_B;
      end
      S_SQ_B: begin
        cmd.mul    = speed ? MS_VZVZ : MS_DZDZ;
        cmd.acc    = AC_SQ_SET;
        state_next = S_SQ_ACC;
      end
      S_SQ_ACC: begin
        cmd.acc = AC_SQ_ADD;
        if (speed) begin
          state_next = S_ROOT_START;
        end else begin
          cmd.mul    = radial ? MS_VYDY : MS_VZDY;
          state_next = S_NUM_B;
        end
      end
      S_NUM_B: begin
        cmd.mul    = radial ? MS_VZDZ : MS_VYDZ;
        cmd.acc    = AC_NUM_SET;
        state_next = S_NUM_ACC;
      end
      S_NUM_ACC: begin
        cmd.acc    = radial ? AC_NUM_ADD : AC_NUM_SUB;
        state_next = S_ROOT_START;
      end
      S_ROOT_START: begin cmd.root_start = 1'b1; state_next = S_ROOT_WAIT; end
      S_ROOT_WAIT: begin
        if (st.root_done) begin
          if (speed) begin
            cmd.vop    = V_ROOT;
            state_next = S_DIFF;
          end else if (st.root_zero) begin
            cmd.vop    = V_ZERO;
            state_next = S_DIFF;
          end else begin
            state_next = S_DIV_START;
          end
        end
      end
      S_DIV_START: begin cmd.div_start = 1'b1; state_next = S_DIV_WAIT; end
      S_DIV_WAIT: begin
        if (st.div_done) begin
          cmd.vop    = V_DIV;
          state_next = S_DIFF;
        end
      end
      S_DIFF:    begin cmd.acc = AC_DIFF; state_next = S_BIN_LO; end
      S_BIN_LO:  begin cmd.mul = MS_DIFF_LO; state_next = S_BIN_HI; end
      S_BIN_HI:  begin cmd.mul = MS_DIFF_HI; cmd.acc = AC_BIN_SET; state_next = S_BIN_ACC; end
      S_BIN_ACC: begin cmd.acc = AC_BIN_ADD; state_next = S_DECIDE; end
      S_DECIDE:  begin cmd.acc = AC_DECIDE; state_next = S_UPDATE; end
      S_UPDATE: begin
        if (!st.out_busy) begin
          cmd.update = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* rtl/core/region_gated_weighted_histogram_core.sv */
// channel   signals                                  item
// in        in_valid / in_ready / in_data            one droplet (drop_in_t)
// out       out_valid / out_ready / out_data         one bin update (drop_out_t)
// cfg       cfg_valid / cfg_ready / cfg_index+data   one register write
//
// diameter and axial modes need neither square root nor divide; transverse speed mode
// runs a 32-step square root, and radial and tangential modes the square root plus a
// 64-step divide, skipped when the radius is zero; the volume and bin products share
// one 33x33 multiplier
// rst is synchronous; it clears the bin valid bits, so the store reads as zero at once
// a finished result waits in the output register while the next droplet is taken;
// the bin write stalls only when that register is still full
module region_gated_weighted_histogram_core import rgwh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  drop_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output drop_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t st;

  assign cfg_ready = 1'b1;

  rgwh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  rgwh_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.accepted |->
      out_data.bin_count == 32'd0 && out_data.bin_weight == 64'd0 &&
      out_data.bin_index == '0)
    else $error("rejected item carries bin data");

  a_accept_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.accepted |-> out_data.bin_count != 32'd0)
    else $error("accepted item left bin count at zero");

  a_update_free: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> !(out_valid && !out_ready))
    else $error("result written over a waiting one");

endmodule

/* tb/region_gated_weighted_histogram_core_tb.sv */
module region_gated_weighted_histogram_core_tb;
  import rgwh_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  drop_in_t    in_data;
  logic        out_valid;
  logic        out_ready;
  drop_out_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_index;
  logic [63:0] cfg_data;

  region_gated_weighted_histogram_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  localparam int LIMIT = 2000000;

  // predictor copy of the block state
  logic [63:0] vol_sum [NUM_BINS];
  logic [31:0] drop_cnt [NUM_BINS];
  logic [2:0]  p_mode;
  logic [63:0] p_box [3];
  logic signed [31:0] p_origin, p_cy, p_cz;
  logic [31:0] p_scale;

  drop_out_t pending_bins[$];
  int errors, n_items, n_acc, cycles;
  int in_idle, out_idle;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout at %0t", $time);
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > x) bit_v >>= 2;
    while (bit_v != 0) begin
      if (x >= res + bit_v) begin
        x -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [63:0] clamp31(logic signed [63:0] x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483647) return -64'sd2147483647;
    return x;
  endfunction

  function automatic bit in_box(logic signed [31:0] p, logic [63:0] b);
    return p >= $signed(b[31:0]) && p <= $signed(b[63:32]);
  endfunction

  function automatic drop_out_t bin_drop(drop_in_t d);
    drop_out_t r;
    bit ok;
    logic signed [63:0] v, dy, dz, num, diff, vy, vz;
    logic [63:0] rad, bin_v, vol, nw;
    logic [127:0] prod;
    ok = in_box(d.pos_x, p_box[0]) && in_box(d.pos_y, p_box[1]) &&
         in_box(d.pos_z, p_box[2]);
    v = 0;
    bin_v = 0;
    if (ok) begin
      case (p_mode)
        MODE_DIAM:  v = {33'd0, d.diameter};
        MODE_AXIAL: v = d.vel_x;
        MODE_SPEED: begin
          vy = d.vel_y;
          vz = d.vel_z;
          v = int_sqrt(vy * vy + vz * vz);
        end
        MODE_RADIAL, MODE_TANGENT: begin
          dy = clamp31(64'(d.pos_y) - p_cy);
          dz = clamp31(64'(d.pos_z) - p_cz);
          rad = int_sqrt(64'(dy * dy) + 64'(dz * dz));
          num = (p_mode == MODE_RADIAL) ? d.vel_y * dy + d.vel_z * dz
                                        : d.vel_z * dy - d.vel_y * dz;
          v = (rad == 0) ? 64'sd0 : num / $signed(rad);
        end
        default: ok = 0;
      endcase
    end
    if (ok) begin
      diff = v - p_origin;
      if (diff < 0) begin
        ok = (p_scale == 0);
      end else begin
        prod = (128'(diff) * p_scale) >> BIN_SHIFT;
        if (prod[127:64] != 0) ok = 0;
        else begin
          bin_v = prod[63:0];
          ok = bin_v < NUM_BINS;
        end
      end
    end
    r = '0;
    if (ok) begin
      prod = 128'(d.diameter) * d.diameter * d.diameter * PI6_Q32;
      prod = prod >> VOL_SHIFT;
      vol = (prod[127:64] != 0) ? '1 : prod[63:0];
      nw = vol_sum[bin_v] + vol;
      if (nw < vol) nw = '1;
      vol_sum[bin_v] = nw;
      if (drop_cnt[bin_v] != '1) drop_cnt[bin_v]++;
      r.accepted = 1;
      r.bin_index = bin_v[IDX_W-1:0];
      r.bin_count = drop_cnt[bin_v];
      r.bin_weight = nw;
    end
    r.batch_done = d.batch_last;
    return r;
  endfunction

  // output side: random stall and compare
  always @(posedge clk) begin
    drop_out_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_bins.size() == 0) begin
          $display("%0t: unexpected item, actual %p", $time, out_data);
          errors++;
        end else begin
          want = pending_bins.pop_front();
          if (out_data.accepted != want.accepted || out_data.bin_index != want.bin_index ||
              out_data.bin_count != want.bin_count ||
              out_data.bin_weight != want.bin_weight ||
              out_data.batch_done != want.batch_done) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, out_data);
            errors++;
          end
          if (out_data.accepted) n_acc++;
        end
      end
      out_ready <= ($urandom_range(99) >= out_idle);
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    case (idx)
      REG_MODE:     p_mode = val[2:0];
      REG_BOX_X:    p_box[0] = val;
      REG_BOX_Y:    p_box[1] = val;
      REG_BOX_Z:    p_box[2] = val;
      REG_ORIGIN:   p_origin = val[31:0];
      REG_SCALE:    p_scale = val[31:0];
      REG_CENTRE_Y: p_cy = val[31:0];
      REG_CENTRE_Z: p_cz = val[31:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_bins.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic send_drop(drop_in_t d, bit typed, drop_out_t typed_res);
    drop_out_t r;
    while ($urandom_range(99) < in_idle) @(posedge clk);
    in_valid <= 1;
    in_data <= d;
    do @(posedge clk); while (!in_ready);
    in_valid <= 0;
    r = bin_drop(d);
    if (typed && r != typed_res) begin
      $display("%0t: predictor disagrees with table, expected %p got %p",
               $time, typed_res, r);
      errors++;
    end
    pending_bins.push_back(r);
    n_items++;
    @(posedge clk);
  endtask

  function automatic drop_in_t rand_drop(bit narrow);
    drop_in_t d;
    d = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if (narrow) begin
      // mostly values of a few units so the box and bins are hit
      d.diameter = 31'($urandom_range(32'h0400_0000));
      d.pos_x = $signed($urandom_range(32'h0600_0000)) - 32'sh0300_0000;
      d.pos_y = $signed($urandom_range(32'h0600_0000)) - 32'sh0300_0000;
      d.pos_z = $signed($urandom_range(32'h0600_0000)) - 32'sh0300_0000;
      d.vel_x = $signed($urandom_range(32'h2000_0000)) - 32'sh1000_0000;
      d.vel_y = $signed($urandom_range(32'h2000_0000)) - 32'sh1000_0000;
      d.vel_z = $signed($urandom_range(32'h2000_0000)) - 32'sh1000_0000;
    end
    d.batch_last = $urandom_range(7) == 0;
    return d;
  endfunction

  typedef struct {
    drop_in_t  d;
    bit        typed;
    drop_out_t res;
  } table_row_t;

  localparam logic [31:0] ONE = 32'h0100_0000;

  initial begin
    table_row_t rows[$];
    table_row_t row;
    drop_in_t d;
    drop_out_t none;
    errors = 0; n_items = 0; n_acc = 0;
    in_idle = 17; out_idle = 75;
    rst = 1; in_valid = 0; in_data = '0; out_ready = 0;
    cfg_valid = 0; cfg_index = REG_MODE; cfg_data = '0;
    for (int i = 0; i < NUM_BINS; i++) begin
      vol_sum[i] = 0;
      drop_cnt[i] = 0;
    end
    p_mode = MODE_DIAM;
    p_box[0] = 64'h7FFFFFFF80000000; p_box[1] = p_box[0]; p_box[2] = p_box[0];
    p_origin = 0; p_scale = 65536; p_cy = 2008233; p_cz = 1739797;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed table under reset settings (diameter mode, one bin per unit)
    none = '0;
    d = '0;
    row.d = d; row.typed = 1; row.res = '{1, 0, 1, 0, 0};
    rows.push_back(row);                                  // zero diameter, bin 0
    d.diameter = 31'(ONE); d.batch_last = 1;
    row.d = d; row.typed = 1; row.res = '{1, 1, 1, 64'd2248839617 << 24, 1};
    rows.push_back(row);                                  // unit droplet, bin 1
    d.diameter = '1;                                      // largest, bin 127 out of range
    row.d = d; row.typed = 1; row.res = none; row.res.batch_done = 1;
    rows.push_back(row);
    d.diameter = 31'h3F00_0000; d.batch_last = 0;         // top bin 63
    row.d = d; row.typed = 0; rows.push_back(row);
    d.diameter = 31'h3FFF_FFFF;
    row.d = d; row.typed = 0; rows.push_back(row);
    d = '1; d.batch_last = 0; d.diameter = 31'h0200_0000;
    row.d = d; row.typed = 0; rows.push_back(row);
    d = {31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
         32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1};
    row.d = d; row.typed = 0; rows.push_back(row);
    foreach (rows[i]) send_drop(rows[i].d, rows[i].typed, rows[i].res);
    drain();

    // every mode on extremes, including zero radius at the axis
    for (int m = 0; m < 8; m++) begin
      write_reg(REG_MODE, 64'(m));
      d = '0; d.diameter = 31'(ONE); d.vel_x = ONE; d.vel_y = 32'h0300_0000;
      d.vel_z = 32'h0400_0000; d.pos_y = p_cy; d.pos_z = p_cz;
      send_drop(d, 0, none);
      d.pos_y = 32'h8000_0000; d.pos_z = 32'h7FFF_FFFF;
      d.vel_y = 32'h8000_0000; d.vel_z = 32'h8000_0000;
      send_drop(d, 0, none);
      d.pos_y = p_cy + ONE; d.pos_z = p_cz;
      d.vel_y = -32'sh0200_0000; d.vel_z = 32'h0500_0000;
      send_drop(d, 0, none);
      drain();
    end
    // scale zero puts everything in bin 0, even below origin
    write_reg(REG_MODE, MODE_AXIAL);
    write_reg(REG_SCALE, 0);
    write_reg(REG_ORIGIN, 32'h7FFF_FFFF);
    d = '0; d.vel_x = 32'h8000_0000; d.diameter = '1;
    send_drop(d, 0, none);
    send_drop(d, 0, none);
    drain();

    // random phases over several settings
    for (int ph = 0; ph < 15; ph++) begin
      if (ph == 5) begin in_idle = 75; out_idle = 17; end
      if (ph == 10) begin in_idle = 0; out_idle = 0; end
      write_reg(REG_MODE, (ph % 6 == 5) ? $urandom_range(7) : ph % 5);
      if (ph % 3 == 0) begin
        write_reg(REG_BOX_X, $urandom);
        write_reg(REG_BOX_X, {32'h0200_0000, 32'hFE00_0000});
        write_reg(REG_BOX_Y, {32'h0280_0000, 32'hFD80_0000});
        write_reg(REG_BOX_Z, {32'h0280_0000, 32'hFD80_0000});
      end else begin
        write_reg(REG_BOX_X, 64'h7FFFFFFF80000000);
        write_reg(REG_BOX_Y, (ph == 4) ? {$urandom, $urandom} : 64'h7FFFFFFF80000000);
        write_reg(REG_BOX_Z, 64'h7FFFFFFF80000000);
      end
      write_reg(REG_ORIGIN, (ph % 4 == 0) ? 32'h0 : (ph % 4 == 1) ?
                32'hF000_0000 : (ph % 4 == 2) ? 32'h8000_0000 : $urandom);
      write_reg(REG_SCALE, (ph == 7) ? 32'hFFFF_FFFF : (ph == 8) ? 32'h0 :
                $urandom_range(32'h0010_0000, 32'h0000_2000));
      write_reg(REG_CENTRE_Y, (ph == 6) ? 32'h8000_0000 : $urandom_range(32'h0100_0000));
      write_reg(REG_CENTRE_Z, (ph == 6) ? 32'h7FFF_FFFF : $urandom_range(32'h0100_0000));
      for (int k = 0; k < 50; k++) begin
        send_drop(rand_drop($urandom_range(9) != 0), 0, none);
        if (ph == 12 && k == 20) begin
          // sender holds until everything is back
          while (pending_bins.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    $display("%0d droplets sent, %0d landed in a bin, all modes and scale extremes",
             n_items, n_acc);
    if (errors == 0 && pending_bins.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
